FILE: design/fqe_pkg.sv
// Package for the fault qualifier with warning escalation.
// Holds sizes, operation and register codes, and the transfer structs.
// No dependencies.
`timescale 1ns / 1ps

package fqe_pkg;

   localparam int CHANNELS   = 16;
   localparam int TIME_BITS  = 32;
   localparam int COUNT_BITS = 8;
   localparam int CH_BITS    = 4;
   localparam int CSR_BITS   = 32;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [1:0] {
      FUNC_POLL  = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_CHECK = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_CHANNEL_ENABLE     = 2'd0,
      CSR_HOLD_TIME          = 2'd1,
      CSR_WARNINGS_TO_LATCH  = 2'd2,
      CSR_WARNING_RESET_TIME = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [1:0]           func;
      logic [TIME_BITS-1:0] now_tick;
      logic [CHANNELS-1:0]  fault_bits;
      logic [CH_BITS-1:0]   channel;
   } req_type;

   typedef struct packed {
      logic [CHANNELS-1:0] error_flags;
      logic [CHANNELS-1:0] warning_flags;
      logic                check_state;
   } rsp_type;

   typedef struct packed {
      logic err;
      logic warn;
      logic check;
   } lane_result_type;

endpackage

FILE: design/fqe_lane.sv
// One channel lane: holds the channel's qualification state and updates it.
// Depends on fqe_pkg.
`timescale 1ns / 1ps

module fqe_lane
   import fqe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  exec,
   input  logic [1:0]            func,
   input  logic [TIME_BITS-1:0]  now_tick,
   input  logic                  enable,
   input  logic                  fault,
   input  logic                  sel,
   input  logic [TIME_BITS-1:0]  hold_time,
   input  logic [COUNT_BITS-1:0] warnings_to_latch,
   input  logic [TIME_BITS-1:0]  warning_reset_time,
   output lane_result_type       result
);

   logic                  err_ff, err_in;
   logic                  warn_ff, warn_in;
   logic                  pend_ff, pend_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic [TIME_BITS-1:0]  lgt_ff, lgt_in;
   logic [TIME_BITS-1:0]  lrt_ff, lrt_in;

   logic                  active;
   logic                  held;
   logic                  report;
   logic                  latch;
   logic                  reset_hit;
   logic                  check;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic [TIME_BITS-1:0]  good_age;
   logic [TIME_BITS-1:0]  report_age;

   assign active     = !err_ff && enable && !pend_ff;
   assign good_age   = now_tick - lgt_ff;
   assign report_age = now_tick - lrt_ff;
   assign held       = good_age >= hold_time;
   assign report     = active && fault && held;
   assign cnt_inc    = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_BITS'(1);
   assign latch      = cnt_inc >= warnings_to_latch;
   // a fresh report leaves an age of zero
   assign reset_hit  = report ? (warning_reset_time == '0) : (report_age >= warning_reset_time);

   always_comb begin
      err_in  = err_ff;
      warn_in = warn_ff;
      pend_in = pend_ff;
      cnt_in  = cnt_ff;
      lgt_in  = lgt_ff;
      lrt_in  = lrt_ff;
      check   = 1'b0;
      unique case (func)
         FUNC_POLL: begin
            if (active && !fault) begin
               lgt_in = now_tick;
            end
            if (report) begin
               lrt_in = now_tick;
               if (latch) begin
                  err_in  = 1'b1;
                  warn_in = 1'b0;
                  cnt_in  = '0;
               end else begin
                  warn_in = 1'b1;
                  pend_in = 1'b1;
                  cnt_in  = cnt_inc;
               end
            end
            if (reset_hit) begin
               warn_in = 1'b0;
               cnt_in  = '0;
               pend_in = 1'b0;
            end
         end
         FUNC_CLEAR: begin
            lgt_in  = now_tick;
            pend_in = 1'b0;
            err_in  = 1'b0;
         end
         FUNC_CHECK: begin
            if (sel) begin
               if (err_ff) begin
                  check = 1'b1;
               end else if (enable && fault) begin
                  err_in = 1'b1;
                  check  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= 1'b0;
         warn_ff <= 1'b0;
         pend_ff <= 1'b0;
         cnt_ff  <= '0;
         lgt_ff  <= '0;
         lrt_ff  <= '0;
      end else if (exec) begin
         err_ff  <= err_in;
         warn_ff <= warn_in;
         pend_ff <= pend_in;
         cnt_ff  <= cnt_in;
         lgt_ff  <= lgt_in;
         lrt_ff  <= lrt_in;
      end
   end

   assign result.err   = err_in;
   assign result.warn  = warn_in;
   assign result.check = check;

endmodule

FILE: design/fqe_merge.sv
// Merge stage: gathers the lane results into one response and holds it.
// Depends on fqe_pkg.
`timescale 1ns / 1ps

module fqe_merge
   import fqe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            exec,
   input  lane_result_type lanes [CHANNELS],
   input  logic            rsp_stall,
   output logic            rsp_valid,
   output rsp_type         rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      data_in.check_state = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         data_in.error_flags[c]   = lanes[c].err;
         data_in.warning_flags[c] = lanes[c].warn;
         data_in.check_state      = data_in.check_state | lanes[c].check;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (exec) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: design/fault_qualifier_escalation_core.sv
// Fault qualifier with warning escalation, top level.
// Depends on fqe_pkg, fqe_lane and fqe_merge.
//
// Usage:
//   req_valid/req_stall/req_data carry one operation (poll, clear errors or
//   check one channel) with the current tick and the raw fault bits.
//   rsp_valid/rsp_stall/rsp_data return one response per request: the error
//   and warning vectors after the operation and the check answer.
//   csr_we/csr_index/csr_wdata write channel_enable, hold_time,
//   warnings_to_latch and warning_reset_time; write only while idle.
// Timing:
//   A request is latched into the item register on transfer and executed by
//   sixteen channel lanes at once when the response register is free or
//   draining; the merge stage registers the lane results as the response.
//   One request per cycle is sustained while the response side keeps up;
//   the per-lane subtract and compare set the cycle time.
// Reset:
//   Synchronous, active high. Clears all channel state and loads the register
//   defaults (warnings_to_latch 1, warning_reset_time 1000).
// Stall:
//   A stalled response holds its data; the item register takes one further
//   request, and req_stall then stays high until the response transfers.
`timescale 1ns / 1ps

module fault_qualifier_escalation_core
   import fqe_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  req_type                 req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rsp_type                 rsp_data,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [CSR_BITS-1:0]     csr_wdata
);

   logic [CHANNELS-1:0]   enable_ff;
   logic [TIME_BITS-1:0]  hold_ff;
   logic [COUNT_BITS-1:0] wtl_ff;
   logic [TIME_BITS-1:0]  wrt_ff;

   logic            item_valid_ff, item_valid_in;
   req_type         item_ff;
   logic            exec;
   logic            take;
   lane_result_type lanes [CHANNELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
         hold_ff   <= '0;
         wtl_ff    <= COUNT_BITS'(1);
         wrt_ff    <= TIME_BITS'(1000);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CHANNEL_ENABLE:     enable_ff <= csr_wdata[CHANNELS-1:0];
            CSR_HOLD_TIME:          hold_ff   <= csr_wdata[TIME_BITS-1:0];
            CSR_WARNINGS_TO_LATCH:  wtl_ff    <= csr_wdata[COUNT_BITS-1:0];
            CSR_WARNING_RESET_TIME: wrt_ff    <= csr_wdata[TIME_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // execute when the response register is free or draining
   assign exec      = item_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = item_valid_ff && !exec;
   assign take      = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (exec) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_data;
      end
   end

   for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
      fqe_lane u_lane (
         .clock              (clock),
         .reset              (reset),
         .exec               (exec),
         .func               (item_ff.func),
         .now_tick           (item_ff.now_tick),
         .enable             (enable_ff[c]),
         .fault              (item_ff.fault_bits[c]),
         .sel                (item_ff.channel == CH_BITS'(c)),
         .hold_time          (hold_ff),
         .warnings_to_latch  (wtl_ff),
         .warning_reset_time (wrt_ff),
         .result             (lanes[c])
      );
   end

   fqe_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .exec      (exec),
      .lanes     (lanes),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec |=> rsp_valid)
      else $error("executed item produced no response");

   a_clear_empties_errors: assert property (@(posedge clock) disable iff (reset)
      exec && item_ff.func == FUNC_CLEAR |=> rsp_data.error_flags == '0)
      else $error("clear left error bits set");

   a_check_matches_error: assert property (@(posedge clock) disable iff (reset)
      exec && item_ff.func == FUNC_CHECK
      |=> rsp_data.check_state == rsp_data.error_flags[$past(item_ff.channel)])
      else $error("check answer disagrees with error bit");

   a_check_zero_otherwise: assert property (@(posedge clock) disable iff (reset)
      exec && item_ff.func != FUNC_CHECK |=> !rsp_data.check_state)
      else $error("check answer set outside a check");

endmodule
